// ----- rtl/matrix4x4_inverse_defines.svh -----
// Assertion helpers shared by the RTL of the 4x4 matrix inverse.
`ifndef MATRIX4X4_INVERSE_DEFINES_SVH
`define MATRIX4X4_INVERSE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define M4INV_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define M4INV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/m4inv_pkg.sv -----
package m4inv_pkg;

    // Element format and the width of the exact intermediate values.
    localparam int DataWidth = 32;
    localparam int FracBits  = 16;
    localparam int WideWidth = 4 * DataWidth + 2 * FracBits + 4;
    localparam int BitCntW   = $clog2(DataWidth);
    localparam int DivCntW   = $clog2(WideWidth);

    typedef logic [WideWidth-1:0] t_wide;
    typedef logic [DataWidth-1:0] t_elem;

    typedef enum logic [3:0] {
        S_LOAD,
        S_TLDY,
        S_TLDX,
        S_TMUL,
        S_TACC,
        S_DLDY,
        S_DMUL,
        S_DACC,
        S_DABS,
        S_KABS,
        S_DIV,
        S_EMIT
    } t_state;

    // Index k skipping the excluded row or column.
    function automatic logic [1:0] m4inv_skip(input logic [1:0] k, input logic [1:0] ex);
        m4inv_skip = (k < ex) ? k : k + 2'd1;
    endfunction

    // Column order of the six permutations of a 3x3 determinant.
    function automatic logic [1:0] m4inv_perm(input logic [2:0] t, input logic [1:0] pos);
        logic [5:0] p;
        case (t)
            3'd0:    p = {2'd2, 2'd1, 2'd0};
            3'd1:    p = {2'd1, 2'd2, 2'd0};
            3'd2:    p = {2'd2, 2'd0, 2'd1};
            3'd3:    p = {2'd0, 2'd2, 2'd1};
            3'd4:    p = {2'd1, 2'd0, 2'd2};
            3'd5:    p = {2'd0, 2'd1, 2'd2};
            default: p = {2'd2, 2'd1, 2'd0};
        endcase
        m4inv_perm = p[2*pos +: 2];
    endfunction

    // Odd permutations enter the determinant with a minus sign.
    function automatic logic m4inv_perm_neg(input logic [2:0] t);
        m4inv_perm_neg = (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
    endfunction

endpackage

// ----- rtl/m4inv_in_if.sv -----
interface m4inv_in_if;
    import m4inv_pkg::*;

    logic  valid;
    logic  ready;
    t_elem element;

    modport source (output valid, output element, input ready);
    modport sink (input valid, input element, output ready);
endinterface

// ----- rtl/m4inv_out_if.sv -----
interface m4inv_out_if;
    import m4inv_pkg::*;

    logic  valid;
    logic  ready;
    t_elem inv_element;
    logic  singular;
    logic  saturated;
    logic  last;

    modport source (output valid, output inv_element, output singular, output saturated,
                    output last, input ready);
    modport sink (input valid, input inv_element, input singular, input saturated,
                  input last, output ready);
endinterface

// ----- rtl/m4inv_alu.sv -----
module m4inv_alu (
    input  m4inv_pkg::t_wide i_a,
    input  m4inv_pkg::t_wide i_b,
    input  logic             i_sub,
    output m4inv_pkg::t_wide o_sum
);
    import m4inv_pkg::*;

    // One wide adder that also subtracts by inverting the second operand.
    assign o_sum = i_a + (i_b ^ {WideWidth{i_sub}}) + t_wide'(i_sub);
endmodule

// ----- rtl/m4inv_fmt.sv -----
module m4inv_fmt (
    input  m4inv_pkg::t_wide i_quot,
    input  logic             i_neg,
    input  logic             i_zero,
    output m4inv_pkg::t_elem o_value,
    output logic             o_sat
);
    import m4inv_pkg::*;

    logic  big;
    t_elem qlow;

    assign big  = |i_quot[WideWidth-1:DataWidth];
    assign qlow = i_quot[DataWidth-1:0];

    // Apply the sign and clamp the magnitude to the element range.
    always_comb begin
        o_value = '0;
        o_sat   = 1'b0;
        if (i_zero) begin
            o_value = '0;
            o_sat   = 1'b0;
        end else if (i_neg) begin
            o_sat = big || (qlow[DataWidth-1] && (|qlow[DataWidth-2:0]));
            if (o_sat) begin
                o_value = {1'b1, {(DataWidth-1){1'b0}}};
            end else begin
                o_value = ~qlow + t_elem'(1);
            end
        end else begin
            o_sat = big || qlow[DataWidth-1];
            if (o_sat) begin
                o_value = {1'b0, {(DataWidth-1){1'b1}}};
            end else begin
                o_value = qlow;
            end
        end
    end
endmodule

// ----- rtl/matrix4x4_inverse.sv -----
// 4x4 matrix inverse by the adjugate in signed Q16.16. The sixteen elements enter one per
// transaction in column-major order; the block accepts one element per cycle while loading.
// After the sixteenth element it stops taking input, forms the sixteen 3x3 minors and the
// determinant exactly, and then sends the sixteen inverse elements in column-major order,
// the last one marked. All of that work runs through a single wide adder: each product is a
// shift-and-add over the 32 bits of one element, and each quotient a restoring division of
// one bit per cycle. After the last element it forms the minors, then the determinant, then
// each result in turn, and an output stall holds it; a singular matrix gives zeros with the
// singular flag.
`include "matrix4x4_inverse_defines.svh"

module matrix4x4_inverse (
    input logic         i_clk,
    input logic         i_rst_n,
    m4inv_in_if.sink    i_elem,
    m4inv_out_if.source o_inv
);
    import m4inv_pkg::*;

    t_state               r_state, n_state;
    logic [3:0]           r_cnt, n_cnt, r_mi, n_mi, r_k, n_k;
    logic [2:0]           r_t, n_t;
    logic                 r_phase, n_phase;
    logic [BitCntW-1:0]   r_bit, n_bit;
    logic [DivCntW-1:0]   r_div, n_div;
    t_wide                r_p, n_p, r_y, n_y, r_acc, n_acc, r_dmag, n_dmag;
    t_wide                r_num, n_num, r_rem, n_rem, r_q, n_q;
    t_elem                r_x, n_x;
    logic                 r_dneg, n_dneg, r_dzero, n_dzero, r_nneg, n_nneg;
    logic                 r_ovalid, n_ovalid, r_osing, n_osing, r_osat, n_osat;
    logic                 r_olast, n_olast;
    t_elem                r_oelem, n_oelem;

    t_elem                r_store [16];
    t_wide                r_minor [16];

    logic [3:0]           rd_addr, mn_addr;
    t_elem                rd_data;
    t_wide                rd_wide, mn_data, remsh;
    logic                 st_we, mn_we;
    t_wide                alu_a, alu_b, alu_sum;
    logic                 alu_sub;
    logic [1:0]           rs0, rs1, rs2, cs0, cs1, cs2;
    logic                 mul_last;
    t_elem                fmt_value;
    logic                 fmt_sat;

    // Rows and columns of the current minor's term.
    assign rs0 = m4inv_skip(2'd0, r_mi[3:2]);
    assign rs1 = m4inv_skip(2'd1, r_mi[3:2]);
    assign rs2 = m4inv_skip(2'd2, r_mi[3:2]);
    assign cs0 = m4inv_skip(m4inv_perm(r_t, 2'd0), r_mi[1:0]);
    assign cs1 = m4inv_skip(m4inv_perm(r_t, 2'd1), r_mi[1:0]);
    assign cs2 = m4inv_skip(m4inv_perm(r_t, 2'd2), r_mi[1:0]);

    // Single read port of the element store, indexed as column then row.
    always_comb begin
        case (r_state)
            S_TLDY:  rd_addr = {cs2, rs2};
            S_TLDX:  rd_addr = {cs1, rs1};
            S_DLDY:  rd_addr = {r_k[1:0], 2'b00};
            default: rd_addr = {cs0, rs0};
        endcase
    end
    assign rd_data = r_store[rd_addr];
    assign rd_wide = {{(WideWidth-DataWidth){rd_data[DataWidth-1]}}, rd_data};

    assign mn_addr = (r_state == S_DLDY) ? {2'b00, r_k[1:0]} : r_k;
    assign mn_data = r_minor[mn_addr];

    assign mul_last = (r_bit == BitCntW'(DataWidth - 1));
    assign remsh    = {r_rem[WideWidth-2:0], r_num[WideWidth-1]};

    m4inv_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum)
    );

    m4inv_fmt u_fmt (
        .i_quot  (r_q),
        .i_neg   (r_nneg ^ r_dneg),
        .i_zero  (r_dzero),
        .o_value (fmt_value),
        .o_sat   (fmt_sat)
    );

    // Sequencer and datapath next state.
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_mi     = r_mi;
        n_k      = r_k;
        n_t      = r_t;
        n_phase  = r_phase;
        n_bit    = r_bit;
        n_div    = r_div;
        n_p      = r_p;
        n_y      = r_y;
        n_x      = r_x;
        n_acc    = r_acc;
        n_dmag   = r_dmag;
        n_num    = r_num;
        n_rem    = r_rem;
        n_q      = r_q;
        n_dneg   = r_dneg;
        n_dzero  = r_dzero;
        n_nneg   = r_nneg;
        n_ovalid = r_ovalid && !o_inv.ready;
        n_oelem  = r_oelem;
        n_osing  = r_osing;
        n_osat   = r_osat;
        n_olast  = r_olast;
        st_we    = 1'b0;
        mn_we    = 1'b0;
        alu_a    = r_p;
        alu_b    = r_y;
        alu_sub  = 1'b0;

        case (r_state)
            S_LOAD: begin
                if (i_elem.valid) begin
                    st_we = 1'b1;
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        n_mi    = '0;
                        n_t     = '0;
                        n_acc   = '0;
                        n_state = S_TLDY;
                    end
                end
            end
            S_TLDY: begin
                n_y     = rd_wide;
                n_p     = '0;
                n_state = S_TLDX;
            end
            S_TLDX: begin
                n_x     = rd_data;
                n_phase = 1'b0;
                n_bit   = '0;
                n_state = S_TMUL;
            end
            S_TMUL, S_DMUL: begin
                // Shift-and-add step; the top multiplier bit carries negative weight.
                alu_sub = mul_last;
                n_p     = r_x[0] ? alu_sum : r_p;
                n_y     = {r_y[WideWidth-2:0], 1'b0};
                n_x     = {1'b0, r_x[DataWidth-1:1]};
                n_bit   = r_bit + BitCntW'(1);
                if (mul_last) begin
                    if (r_state == S_DMUL) begin
                        n_state = S_DACC;
                    end else if (!r_phase) begin
                        n_y     = n_p;
                        n_p     = '0;
                        n_x     = rd_data;
                        n_phase = 1'b1;
                        n_bit   = '0;
                    end else begin
                        n_state = S_TACC;
                    end
                end
            end
            S_TACC: begin
                alu_a   = r_acc;
                alu_b   = r_p;
                alu_sub = m4inv_perm_neg(r_t);
                n_acc   = alu_sum;
                n_state = S_TLDY;
                if (r_t == 3'd5) begin
                    mn_we = 1'b1;
                    n_acc = '0;
                    n_t   = '0;
                    n_mi  = r_mi + 4'd1;
                    if (r_mi == 4'd15) begin
                        n_k     = '0;
                        n_state = S_DLDY;
                    end
                end else begin
                    n_t = r_t + 3'd1;
                end
            end
            S_DLDY: begin
                n_y     = mn_data;
                n_x     = rd_data;
                n_p     = '0;
                n_bit   = '0;
                n_state = S_DMUL;
            end
            S_DACC: begin
                // Expansion along row zero with alternating signs.
                alu_a   = r_acc;
                alu_b   = r_p;
                alu_sub = r_k[0];
                n_acc   = alu_sum;
                n_k     = r_k + 4'd1;
                if (r_k == 4'd3) begin
                    n_state = S_DABS;
                end else begin
                    n_state = S_DLDY;
                end
            end
            S_DABS: begin
                alu_a   = '0;
                alu_b   = r_acc;
                alu_sub = 1'b1;
                n_dneg  = r_acc[WideWidth-1];
                n_dzero = (r_acc == '0);
                n_dmag  = r_acc[WideWidth-1] ? alu_sum : r_acc;
                n_k     = '0;
                n_state = S_KABS;
            end
            S_KABS: begin
                // Cofactor sign follows the parity of row plus column.
                alu_a   = '0;
                alu_b   = mn_data;
                alu_sub = 1'b1;
                n_nneg  = mn_data[WideWidth-1] ^ r_k[0] ^ r_k[2];
                n_num   = (mn_data[WideWidth-1] ? alu_sum : mn_data) << (2 * FracBits);
                n_rem   = '0;
                n_q     = '0;
                n_div   = '0;
                n_state = r_dzero ? S_EMIT : S_DIV;
            end
            S_DIV: begin
                // Restoring division, one quotient bit per cycle.
                alu_a   = remsh;
                alu_b   = r_dmag;
                alu_sub = 1'b1;
                n_rem   = alu_sum[WideWidth-1] ? remsh : alu_sum;
                n_q     = {r_q[WideWidth-2:0], !alu_sum[WideWidth-1]};
                n_num   = {r_num[WideWidth-2:0], 1'b0};
                n_div   = r_div + DivCntW'(1);
                if (r_div == DivCntW'(WideWidth - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ovalid || o_inv.ready) begin
                    n_ovalid = 1'b1;
                    n_oelem  = fmt_value;
                    n_osing  = r_dzero;
                    n_osat   = fmt_sat;
                    n_olast  = (r_k == 4'd15);
                    n_k      = r_k + 4'd1;
                    n_state  = (r_k == 4'd15) ? S_LOAD : S_KABS;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    // Datapath registers and the two stores.
    always_ff @(posedge i_clk) begin
        r_mi    <= n_mi;
        r_k     <= n_k;
        r_t     <= n_t;
        r_phase <= n_phase;
        r_bit   <= n_bit;
        r_div   <= n_div;
        r_p     <= n_p;
        r_y     <= n_y;
        r_x     <= n_x;
        r_acc   <= n_acc;
        r_dmag  <= n_dmag;
        r_num   <= n_num;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_dneg  <= n_dneg;
        r_dzero <= n_dzero;
        r_nneg  <= n_nneg;
        r_oelem <= n_oelem;
        r_osing <= n_osing;
        r_osat  <= n_osat;
        r_olast <= n_olast;
        if (st_we) begin
            r_store[r_cnt] <= i_elem.element;
        end
        if (mn_we) begin
            r_minor[r_mi] <= alu_sum;
        end
    end

    assign i_elem.ready      = (r_state == S_LOAD);
    assign o_inv.valid       = r_ovalid;
    assign o_inv.inv_element = r_oelem;
    assign o_inv.singular    = r_osing;
    assign o_inv.saturated   = r_osat;
    assign o_inv.last        = r_olast;

    `M4INV_ASSERT_NEXT(a_load_done, i_clk, i_rst_n, r_state == S_LOAD && i_elem.valid && r_cnt == 4'd15, r_state == S_TLDY, "sixteenth element did not start the computation")
    `M4INV_ASSERT_IMP(a_singular_zero, i_clk, i_rst_n, o_inv.valid && o_inv.singular, o_inv.inv_element == '0 && !o_inv.saturated, "singular result is not zero")
    `M4INV_ASSERT_NEXT(a_last_drains, i_clk, i_rst_n, o_inv.valid && o_inv.ready && o_inv.last, !o_inv.valid, "result follows the last one of a matrix")
endmodule
